### hw/rtl/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg: shared types and codes for the ordered list store
// Opcodes, status codes, field widths and the per-cell command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package ols_pkg;

	localparam int OPC_W  = 3;
	localparam int ST_W   = 2;
	localparam int WORD_W = 32;

	// Operation codes
	localparam logic [OPC_W-1:0] OP_INSERT_AT   = 3'd0;
	localparam logic [OPC_W-1:0] OP_INSERT_HEAD = 3'd1;
	localparam logic [OPC_W-1:0] OP_INSERT_TAIL = 3'd2;
	localparam logic [OPC_W-1:0] OP_REMOVE_AT   = 3'd3;
	localparam logic [OPC_W-1:0] OP_READ_AT     = 3'd4;
	localparam logic [OPC_W-1:0] OP_REPLACE_AT  = 3'd5;
	localparam logic [OPC_W-1:0] OP_CLEAR       = 3'd6;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	// Broadcast to every cell; at most one bit set per cycle
	typedef struct packed {
		logic shift_up;    // open a slot at pos, load value there
		logic shift_down;  // close the slot at pos
		logic write;       // overwrite the entry at pos
	} ols_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/ols_if.sv
// ----------------------------------------------------------------------------
// ols_if: request and response channels of the ordered list store
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ols_req_if import ols_pkg::*; #(
	parameter int POS_W = 5
) ();
	logic                     valid;
	logic                     ready;
	logic [OPC_W-1:0]         opcode;
	logic [POS_W-1:0]         position;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, opcode, position, value, input ready);
	modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface ols_rsp_if import ols_pkg::*; #(
	parameter int POS_W = 5
) ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] data;
	logic [ST_W-1:0]          status;
	logic [POS_W-1:0]         length;

	modport source (output valid, data, status, length, input ready);
	modport sink   (input valid, data, status, length, output ready);
endinterface

`default_nettype wire

### hw/rtl/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list of signed 32-bit words
// Positional insert and remove over a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries opcode, position and value; rsp returns data, status and the
//   list length after the operation. Every request item yields exactly one
//   response item.
//   The list lives in DEPTH cells; an insert or remove shifts all cells
//   above the position by one slot in a single cycle, each cell loading from
//   its neighbor. Reads select the addressed cell onto an OR bus.
//   The response is registered and valid in the cycle after the
//   request is taken. Throughput: one item per cycle while rsp.ready is high,
//   set by the single update of the cell row and the length counter per cycle.
//   Stall: the output register holds its item while rsp.ready is low; a new
//   request is taken only when that register is empty or being drained.
//   Reset: clears the length to zero and empties the output register; the
//   cell contents are not cleared and are reachable only once rewritten.
//   position and length are $clog2(DEPTH+1) bits wide; channel instances
//   must use that width.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store import ols_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	ols_req_if.sink   req,
	ols_rsp_if.source rsp
);

	localparam int               CNT_W     = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic              acc;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  pos_in;
	logic [CNT_W-1:0]  eff_pos;
	logic [ST_W-1:0]   st;
	logic              rd_sel;
	ols_cmd_t          cmd;
	logic [WORD_W-1:0] rd_or;
	logic [WORD_W-1:0] entry_w [DEPTH];
	logic [WORD_W-1:0] rd_w [DEPTH];

	logic              out_valid_q;
	logic [WORD_W-1:0] out_data_q;
	logic [ST_W-1:0]   out_status_q;
	logic [CNT_W-1:0]  out_length_q;

	assign req.ready = !out_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign pos_in    = req.position;

	// position actually used by the operation
	always_comb begin
		eff_pos = pos_in;
		if (req.opcode == OP_INSERT_HEAD) begin
			eff_pos = '0;
		end else if (req.opcode == OP_INSERT_TAIL) begin
			eff_pos = count_q;
		end
	end

	// decode: status, next length, cell command
	always_comb begin
		st      = ST_OK;
		count_d = count_q;
		rd_sel  = 1'b0;
		cmd     = '0;
		unique case (req.opcode) inside
			OP_INSERT_AT, OP_INSERT_HEAD, OP_INSERT_TAIL: begin
				if (count_q == DEPTH_CNT) begin
					st = ST_FULL;
				end else if (eff_pos > count_q) begin
					st = ST_RANGE;
				end else begin
					cmd.shift_up = acc;
					count_d      = count_q + 1'b1;
				end
			end
			OP_REMOVE_AT, OP_READ_AT, OP_REPLACE_AT: begin
				if (count_q == '0) begin
					st = ST_EMPTY;
				end else if (eff_pos >= count_q) begin
					st = ST_RANGE;
				end else if (req.opcode == OP_REMOVE_AT) begin
					cmd.shift_down = acc;
					rd_sel         = 1'b1;
					count_d        = count_q - 1'b1;
				end else if (req.opcode == OP_READ_AT) begin
					rd_sel = 1'b1;
				end else begin
					cmd.write = acc;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// row of cells, each wired to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = req.value;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = entry_w[i];
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		ols_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (eff_pos),
			.value (req.value),
			.left  (left_w),
			.right (right_w),
			.entry (entry_w[i]),
			.rd    (rd_w[i])
		);
	end

	// read bus: at most one cell is addressed
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | rd_w[i];
		end
	end

	// length counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_data_q   <= rd_sel ? rd_or : '0;
			out_status_q <= st;
			out_length_q <= count_d;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_data_q;
	assign rsp.status = out_status_q;
	assign rsp.length = out_length_q;

	// length never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("list length above capacity");

	// a pending response reports the current length
	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_length_q == count_q)
		else $error("response length differs from list length");

	// rejected operations leave the length alone
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && st != ST_OK) |=> $stable(count_q))
		else $error("rejected item changed the length");

	// full is reported only on a full list
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && st == ST_FULL) |-> count_q == DEPTH_CNT)
		else $error("full status on a list with room");

	// at most one cell command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting cell commands");

endmodule

`default_nettype wire

### hw/rtl/ols_cell.sv
// ----------------------------------------------------------------------------
// ols_cell: one slot of the list
// Holds one word and takes it from its left or right neighbor, from the
// request value, or keeps it, as the broadcast command and its index decide.
// ----------------------------------------------------------------------------
`default_nettype none

module ols_cell import ols_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  ols_cmd_t          cmd,
	input  logic [CNT_W-1:0]  pos,
	input  logic [WORD_W-1:0] value,
	input  logic [WORD_W-1:0] left,
	input  logic [WORD_W-1:0] right,
	output logic [WORD_W-1:0] entry,
	output logic [WORD_W-1:0] rd
);

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

	logic              hit;
	logic              above;
	logic [WORD_W-1:0] entry_q;
	logic [WORD_W-1:0] entry_d;

	assign hit   = (pos == MY_POS);
	assign above = (MY_POS > pos);

	// next word for this slot
	always_comb begin
		entry_d = entry_q;
		if (cmd.shift_up) begin
			if (above) begin
				entry_d = left;
			end else if (hit) begin
				entry_d = value;
			end
		end else if (cmd.shift_down) begin
			if (above || hit) begin
				entry_d = right;
			end
		end else if (cmd.write && hit) begin
			entry_d = value;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;
	// only the addressed cell drives the read bus
	assign rd    = hit ? entry_q : '0;

endmodule

`default_nettype wire

### verif/tb_ordered_list_store.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_store: self-checking bench for the ordered list store
// Drives list operations over the request channel, predicts every response
// with a behavioral copy of the list, and compares data, status and length.
// Directed tests cover empty, boundary and full lists; random traffic then
// grows, shrinks and churns the list with idle bursts on both channels.
// ----------------------------------------------------------------------------

module tb_ordered_list_store;
	import ols_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH     = 16;
	localparam int POS_W          = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W          = $clog2(LIST_DEPTH);
	localparam int WATCHDOG_LIMIT = 500;

	// opcode 7 is not assigned and must behave as a no-op
	localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} traffic_mix_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic [ST_W-1:0]          status;
		logic [POS_W-1:0]         length;
	} list_result_t;

	logic clk;
	logic arst_n;

	ols_req_if #(.POS_W(POS_W)) req_ch ();
	ols_rsp_if #(.POS_W(POS_W)) rsp_ch ();

	ordered_list_store #(.DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list
	logic signed [WORD_W-1:0] list_words [LIST_DEPTH];
	int                       list_len;

	list_result_t pending_results [$];
	int           mismatches;
	bit           no_idle;
	int           stall_left;
	int           quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one operation to the shadow list; returns the expected response
	function automatic list_result_t apply_list_op(input logic [OPC_W-1:0] opc,
			input logic [POS_W-1:0] pos, input logic signed [WORD_W-1:0] word);
		list_result_t res;
		int           slot;
		res.data   = '0;
		res.status = ST_OK;
		case (opc)
			OP_INSERT_AT, OP_INSERT_HEAD, OP_INSERT_TAIL: begin
				if (opc == OP_INSERT_HEAD) begin
					slot = 0;
				end else if (opc == OP_INSERT_TAIL) begin
					slot = list_len;
				end else begin
					slot = int'(pos);
				end
				// full is checked ahead of the position
				if (list_len >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else if (slot > list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
					list_words[slot] = word;
					list_len++;
				end
			end
			OP_REMOVE_AT, OP_READ_AT, OP_REPLACE_AT: begin
				if (list_len == 0) begin
					res.status = ST_EMPTY;
				end else if (int'(pos) >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					case (opc)
						OP_READ_AT: begin
							res.data = list_words[pos[IDX_W-1:0]];
						end
						OP_REPLACE_AT: begin
							list_words[pos[IDX_W-1:0]] = word;
						end
						default: begin
							res.data = list_words[pos[IDX_W-1:0]];
							for (int i = int'(pos); i + 1 < list_len; i++)
								list_words[i] = list_words[i+1];
							list_len--;
						end
					endcase
				end
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		res.length = POS_W'(list_len);
		return res;
	endfunction

	// Send one item, with an occasional idle burst ahead of it
	task automatic send_op(input logic [OPC_W-1:0] opc, input logic [POS_W-1:0] pos,
			input logic signed [WORD_W-1:0] word);
		int gap;
		if (!no_idle && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= opc;
		req_ch.position <= pos;
		req_ch.value    <= word;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_results.push_back(apply_list_op(opc, pos, word));
	endtask

	// Random word with extra weight on the signed extremes
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly in-range positions; now and then anything the field can hold
	function automatic logic [POS_W-1:0] pick_position(input logic [OPC_W-1:0] opc);
		if ($urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 31));
		if (opc == OP_INSERT_AT) return POS_W'($urandom_range(0, list_len));
		if (list_len == 0) return '0;
		return POS_W'($urandom_range(0, list_len - 1));
	endfunction

	function automatic logic [OPC_W-1:0] pick_opcode(input traffic_mix_t mix);
		int ins_w;
		int rem_w;
		int r;
		case (mix)
			MIX_GROW:   begin ins_w = 70; rem_w = 10; end
			MIX_SHRINK: begin ins_w = 15; rem_w = 55; end
			default:    begin ins_w = 40; rem_w = 25; end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins_w) begin
			case ($urandom_range(0, 2))
				0:       return OP_INSERT_AT;
				1:       return OP_INSERT_HEAD;
				default: return OP_INSERT_TAIL;
			endcase
		end
		if (r < ins_w + rem_w) return OP_REMOVE_AT;
		if (r < 97) return ($urandom_range(0, 1) == 0) ? OP_READ_AT : OP_REPLACE_AT;
		if (r < 99) return OP_CLEAR;
		return OP_UNUSED;
	endfunction

	// Episodes of growing, shrinking and churning traffic
	task automatic run_list_traffic(input int n_items);
		traffic_mix_t     mix;
		int               burst;
		logic [OPC_W-1:0] opc;
		while (n_items > 0) begin
			mix   = traffic_mix_t'($urandom_range(0, 2));
			burst = $urandom_range(10, 40);
			while (burst > 0 && n_items > 0) begin
				opc = pick_opcode(mix);
				send_op(opc, pick_position(opc), pick_word());
				burst--;
				n_items--;
			end
		end
	endtask

	// Every access on an empty list, the unused opcode, clear while empty
	task automatic test_empty_list();
		send_op(OP_READ_AT, 0, 0);
		send_op(OP_REMOVE_AT, 5, 0);
		send_op(OP_REPLACE_AT, 0, 32'sd123);
		send_op(OP_INSERT_AT, 1, 32'sd7);
		send_op(OP_UNUSED, 31, '1);
		send_op(OP_CLEAR, 0, 0);
	endtask

	// Extreme words, ignored position on head and tail inserts, append at
	// count, accesses at and past the end
	task automatic test_edge_positions();
		send_op(OP_INSERT_AT, 0, 32'sh8000_0000);
		send_op(OP_INSERT_HEAD, 31, 32'sh7FFF_FFFF);
		send_op(OP_INSERT_TAIL, 17, '1);
		send_op(OP_INSERT_AT, 3, '0);
		send_op(OP_INSERT_AT, 5, 32'sh1234_5678);
		send_op(OP_READ_AT, 3, 0);
		send_op(OP_READ_AT, 4, 0);
		send_op(OP_READ_AT, 31, 0);
		send_op(OP_REPLACE_AT, 1, 32'sh5555_5555);
		send_op(OP_REPLACE_AT, 16, 32'shAAAA_AAAA);
		send_op(OP_READ_AT, 1, 0);
		send_op(OP_REMOVE_AT, 1, 0);
		send_op(OP_REMOVE_AT, 3, 0);
		send_op(OP_REMOVE_AT, 0, 0);
	endtask

	// Fill to capacity, then inserts must report full regardless of position
	task automatic test_full_list();
		logic [POS_W-1:0] pos;
		send_op(OP_CLEAR, 0, 0);
		while (list_len < LIST_DEPTH) begin
			pos = POS_W'($urandom_range(0, list_len));
			send_op(OP_INSERT_AT, pos, pick_word());
		end
		send_op(OP_INSERT_HEAD, 0, 32'sd1);
		send_op(OP_INSERT_TAIL, 0, 32'sd2);
		send_op(OP_INSERT_AT, 31, 32'sd3);
		send_op(OP_READ_AT, POS_W'(LIST_DEPTH - 1), 0);
		send_op(OP_REMOVE_AT, POS_W'(LIST_DEPTH - 1), 0);
		send_op(OP_INSERT_AT, POS_W'(LIST_DEPTH - 1), 32'sh0F0F_0F0F);
	endtask

	task automatic test_random_traffic();
		run_list_traffic(900);
	endtask

	// Closing stretch with both channels running flat out
	task automatic test_steady_stream();
		no_idle = 1'b1;
		run_list_traffic(150);
	endtask

	// Response ready with random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left   <= $urandom_range(0, 7);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare each response with the oldest prediction
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected response: data %0d status %0d length %0d",
					rsp_ch.data, rsp_ch.status, rsp_ch.length);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.data !== want.data) begin
					$error("data: expected %0d, got %0d", want.data, rsp_ch.data);
					mismatches++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, rsp_ch.length);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles with no traffic on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mismatches      = 0;
		no_idle         = 1'b0;
		stall_left      = 0;
		quiet_cycles    = 0;
		list_len        = 0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.opcode   = OP_CLEAR;
		req_ch.position = '0;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edge_positions();
		test_full_list();
		test_random_traffic();
		test_steady_stream();
		req_ch.valid <= 1'b0;

		// drain all pending predictions before the verdict
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/ols_pkg.sv
hw/rtl/ols_if.sv
hw/rtl/ols_cell.sv
hw/rtl/ordered_list_store.sv
verif/tb_ordered_list_store.sv
